// ----- sv/assert_macros.svh -----
// assertion macros used by the radial brush stamp rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock edge out of reset
`define RBHS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rbhs check failed");

// next-cycle implication
`define RBHS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rbhs check failed");

`endif

// ----- sv/rbhs_pkg.sv -----
// types and constants shared by the radial brush stamp modules
package rbhs_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int FRAC_BITS  = 6;

   localparam int CELL_W   = 10;
   localparam int POS_W    = 16;
   localparam int RAD_W    = 17;
   localparam int STR_W    = 18;
   localparam int HEIGHT_W = 17;
   localparam int COUNT_W  = 21;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 18;

   localparam int D2_W    = 2 * POS_W;
   localparam int ROOT_W  = POS_W;
   localparam int EDGE_W  = POS_W + 2;
   localparam int MAG_W   = STR_W;
   localparam int PROD_W  = MAG_W + EDGE_W;
   localparam int QUOT_W  = MAG_W;
   localparam int SUM_W   = HEIGHT_W + 2;
   localparam int STEP_W  = 5;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic [HEIGHT_W-1:0] HEIGHT_ONE = HEIGHT_W'(65536);
   localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};

   localparam logic [STATUS_W-1:0] STATUS_APPLIED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOOP    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REJECT  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STRENGTH = 2'd3;

   typedef struct packed {
      logic [POS_W-1:0] center_x;
      logic [POS_W-1:0] center_y;
      logic [RAD_W-1:0] radius;
      logic [STR_W-1:0] strength;
   } cfg_type;

   typedef struct packed {
      logic [HEIGHT_W-1:0] old_height;
      logic                final_cell;
      logic [STATUS_W-1:0] status;
      logic                active;
      logic [D2_W-1:0]     d2;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

// ----- sv/rbhs_front.sv -----
// front end: accepts a request, measures squared distance, classifies and queues it
module rbhs_front (
   input  logic                        clock,
   input  logic                        reset,
   input  rbhs_pkg::cfg_type           cfg,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [rbhs_pkg::CELL_W-1:0] req_cell_x,
   input  logic [rbhs_pkg::CELL_W-1:0] req_cell_y,
   input  logic [rbhs_pkg::HEIGHT_W-1:0] req_old_height,
   input  logic                        req_final_cell,
   input  rbhs_pkg::fifo_status_type   fifo_stat,
   output logic                        fifo_push,
   output rbhs_pkg::entry_type         fifo_data
);

   typedef enum logic [1:0] {F_IDLE, F_SQUARE, F_PUSH} front_state_type;

   front_state_type state_ff, state_in;
   logic [rbhs_pkg::POS_W-1:0]    adx_ff, adx_in, ady_ff, ady_in;
   logic [rbhs_pkg::D2_W-1:0]     sqx_ff, sqx_in, sqy_ff, sqy_in, rr_ff, rr_in;
   logic [rbhs_pkg::HEIGHT_W-1:0] old_ff, old_in;
   logic                          last_ff, last_in;
   logic [rbhs_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                          on_map_ff, on_map_in;

   logic [rbhs_pkg::POS_W-1:0] xpos, ypos;
   logic [rbhs_pkg::POS_W:0]   diff_x, diff_y;
   logic [rbhs_pkg::D2_W:0]    d2_sum;
   logic                       in_brush;

   assign xpos   = rbhs_pkg::POS_W'(req_cell_x) << rbhs_pkg::FRAC_BITS;
   assign ypos   = rbhs_pkg::POS_W'(req_cell_y) << rbhs_pkg::FRAC_BITS;
   assign diff_x = {1'b0, xpos} - {1'b0, cfg.center_x};
   assign diff_y = {1'b0, ypos} - {1'b0, cfg.center_y};
   assign d2_sum = (rbhs_pkg::D2_W + 1)'(sqx_ff) + (rbhs_pkg::D2_W + 1)'(sqy_ff);
   assign in_brush = d2_sum <= (rbhs_pkg::D2_W + 1)'(rr_ff);

   assign req_stall = (state_ff != F_IDLE);

   always_comb begin
      state_in  = state_ff;
      adx_in    = adx_ff;
      ady_in    = ady_ff;
      sqx_in    = sqx_ff;
      sqy_in    = sqy_ff;
      rr_in     = rr_ff;
      old_in    = old_ff;
      last_in   = last_ff;
      status_in = status_ff;
      on_map_in = on_map_ff;
      fifo_push = 1'b0;
      fifo_data.old_height = old_ff;
      fifo_data.final_cell = last_ff;
      fifo_data.status     = status_ff;
      fifo_data.active     = (status_ff == rbhs_pkg::STATUS_APPLIED) && on_map_ff && in_brush;
      fifo_data.d2         = d2_sum[rbhs_pkg::D2_W-1:0];
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               adx_in    = diff_x[rbhs_pkg::POS_W] ? rbhs_pkg::POS_W'(-diff_x)
                                                   : diff_x[rbhs_pkg::POS_W-1:0];
               ady_in    = diff_y[rbhs_pkg::POS_W] ? rbhs_pkg::POS_W'(-diff_y)
                                                   : diff_y[rbhs_pkg::POS_W-1:0];
               old_in    = req_old_height;
               last_in   = req_final_cell;
               on_map_in = (int'(req_cell_x) < rbhs_pkg::MAX_WIDTH) &&
                           (int'(req_cell_y) < rbhs_pkg::MAX_HEIGHT);
               if (cfg.radius[rbhs_pkg::RAD_W-1]) begin
                  status_in = rbhs_pkg::STATUS_REJECT;
               end else if (cfg.strength == '0) begin
                  status_in = rbhs_pkg::STATUS_NOOP;
               end else begin
                  status_in = rbhs_pkg::STATUS_APPLIED;
               end
               state_in = F_SQUARE;
            end
         end
         F_SQUARE: begin
            sqx_in   = rbhs_pkg::D2_W'(adx_ff) * rbhs_pkg::D2_W'(adx_ff);
            sqy_in   = rbhs_pkg::D2_W'(ady_ff) * rbhs_pkg::D2_W'(ady_ff);
            rr_in    = rbhs_pkg::D2_W'(cfg.radius[rbhs_pkg::POS_W-1:0]) *
                       rbhs_pkg::D2_W'(cfg.radius[rbhs_pkg::POS_W-1:0]);
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!fifo_stat.full) begin
               fifo_push = 1'b1;
               state_in  = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      adx_ff    <= adx_in;
      ady_ff    <= ady_in;
      sqx_ff    <= sqx_in;
      sqy_ff    <= sqy_in;
      rr_ff     <= rr_in;
      old_ff    <= old_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      on_map_ff <= on_map_in;
   end

endmodule

// ----- sv/rbhs_fifo.sv -----
// short request queue between the front and back ends
module rbhs_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  rbhs_pkg::entry_type       push_data,
   input  logic                      pop,
   output rbhs_pkg::entry_type       pop_data,
   output rbhs_pkg::fifo_status_type stat
);

   rbhs_pkg::entry_type slot_ff [rbhs_pkg::FIFO_DEPTH];
   logic [rbhs_pkg::FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [rbhs_pkg::FIFO_AW:0]   count_ff, count_in;

   assign stat.full  = (count_ff == (rbhs_pkg::FIFO_AW + 1)'(rbhs_pkg::FIFO_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/rbhs_back.sv -----
// back end: square root, falloff divide, clamp, change count and response register
module rbhs_back (
   input  logic                            clock,
   input  logic                            reset,
   input  rbhs_pkg::cfg_type               cfg,
   input  rbhs_pkg::fifo_status_type       fifo_stat,
   input  rbhs_pkg::entry_type             fifo_data,
   output logic                            fifo_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rbhs_pkg::HEIGHT_W-1:0]   rsp_new_height,
   output logic                            rsp_write_enable,
   output logic [rbhs_pkg::STATUS_W-1:0]   rsp_pass_status,
   output logic [rbhs_pkg::COUNT_W-1:0]    rsp_cells_changed,
   output logic                            rsp_pass_done
);

   typedef enum logic [2:0] {B_IDLE, B_SQRT, B_NUM, B_MUL, B_DIV, B_DONE} back_state_type;

   back_state_type state_ff, state_in;
   logic [rbhs_pkg::HEIGHT_W-1:0] old_ff, old_in;
   logic                          last_ff, last_in;
   logic [rbhs_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                          active_ff, active_in;
   logic [rbhs_pkg::D2_W-1:0]     rad_ff, rad_in, root_ff, root_in, bit_ff, bit_in;
   logic [rbhs_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [rbhs_pkg::EDGE_W-1:0]   edge_ff, edge_in, num_ff, num_in;
   logic [rbhs_pkg::PROD_W-1:0]   rem_ff, rem_in, dsr_ff, dsr_in;
   logic [rbhs_pkg::QUOT_W-1:0]   quot_ff, quot_in;
   logic [rbhs_pkg::COUNT_W-1:0]  counter_ff, counter_in;

   logic                          out_valid_ff, out_valid_in;
   logic [rbhs_pkg::HEIGHT_W-1:0] out_height_ff, out_height_in;
   logic                          out_we_ff, out_we_in;
   logic [rbhs_pkg::STATUS_W-1:0] out_status_ff, out_status_in;
   logic [rbhs_pkg::COUNT_W-1:0]  out_count_ff, out_count_in;
   logic                          out_done_ff, out_done_in;

   logic                          neg;
   logic [rbhs_pkg::STR_W-1:0]    abs_strength;
   logic [rbhs_pkg::D2_W:0]       trial;
   logic [rbhs_pkg::SUM_W-1:0]    delta, sum;
   logic [rbhs_pkg::HEIGHT_W-1:0] clamped;
   logic                          changed;
   logic [rbhs_pkg::COUNT_W-1:0]  count_next;

   assign neg          = cfg.strength[rbhs_pkg::STR_W-1];
   assign abs_strength = neg ? -cfg.strength : cfg.strength;
   assign trial        = (rbhs_pkg::D2_W + 1)'(root_ff) + (rbhs_pkg::D2_W + 1)'(bit_ff);

   // signed falloff added to the old height, then clamped to 0..1.0
   assign delta = neg ? -rbhs_pkg::SUM_W'(quot_ff) : rbhs_pkg::SUM_W'(quot_ff);
   assign sum   = rbhs_pkg::SUM_W'(old_ff) + delta;
   always_comb begin
      if (sum[rbhs_pkg::SUM_W-1]) begin
         clamped = '0;
      end else if (sum > rbhs_pkg::SUM_W'(rbhs_pkg::HEIGHT_ONE)) begin
         clamped = rbhs_pkg::HEIGHT_ONE;
      end else begin
         clamped = sum[rbhs_pkg::HEIGHT_W-1:0];
      end
   end
   assign changed    = active_ff && (clamped != old_ff);
   assign count_next = (changed && counter_ff != rbhs_pkg::COUNT_MAX) ? counter_ff + 1'b1
                                                                       : counter_ff;

   assign rsp_valid         = out_valid_ff;
   assign rsp_new_height    = out_height_ff;
   assign rsp_write_enable  = out_we_ff;
   assign rsp_pass_status   = out_status_ff;
   assign rsp_cells_changed = out_count_ff;
   assign rsp_pass_done     = out_done_ff;

   always_comb begin
      state_in      = state_ff;
      old_in        = old_ff;
      last_in       = last_ff;
      status_in     = status_ff;
      active_in     = active_ff;
      rad_in        = rad_ff;
      root_in       = root_ff;
      bit_in        = bit_ff;
      step_in       = step_ff;
      edge_in       = edge_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      dsr_in        = dsr_ff;
      quot_in       = quot_ff;
      counter_in    = counter_ff;
      out_valid_in  = out_valid_ff;
      out_height_in = out_height_ff;
      out_we_in     = out_we_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      out_done_in   = out_done_ff;
      fifo_pop      = 1'b0;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         B_IDLE: begin
            if (!fifo_stat.empty) begin
               fifo_pop  = 1'b1;
               old_in    = fifo_data.old_height;
               last_in   = fifo_data.final_cell;
               status_in = fifo_data.status;
               active_in = fifo_data.active;
               rad_in    = fifo_data.d2;
               root_in   = '0;
               bit_in    = rbhs_pkg::D2_W'(1) << (rbhs_pkg::D2_W - 2);
               step_in   = '0;
               state_in  = fifo_data.active ? B_SQRT : B_DONE;
            end
         end
         B_SQRT: begin
            // one root bit per cycle, restoring
            if ((rbhs_pkg::D2_W + 1)'(rad_ff) >= trial) begin
               rad_in  = rad_ff - trial[rbhs_pkg::D2_W-1:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            step_in = step_ff + 1'b1;
            if (step_ff == rbhs_pkg::STEP_W'(rbhs_pkg::ROOT_W - 1)) begin
               state_in = B_NUM;
            end
         end
         B_NUM: begin
            edge_in  = (rbhs_pkg::EDGE_W'(cfg.radius[rbhs_pkg::POS_W-1:0]) << 1) +
                       rbhs_pkg::EDGE_W'(1 << rbhs_pkg::FRAC_BITS);
            num_in   = (rbhs_pkg::EDGE_W'(cfg.radius[rbhs_pkg::POS_W-1:0]) << 1) +
                       rbhs_pkg::EDGE_W'(1 << rbhs_pkg::FRAC_BITS) -
                       (rbhs_pkg::EDGE_W'(root_ff[rbhs_pkg::ROOT_W-1:0]) << 1);
            state_in = B_MUL;
         end
         B_MUL: begin
            rem_in   = rbhs_pkg::PROD_W'(abs_strength[rbhs_pkg::MAG_W-1:0]) *
                       rbhs_pkg::PROD_W'(num_ff);
            dsr_in   = rbhs_pkg::PROD_W'(edge_ff) << (rbhs_pkg::QUOT_W - 1);
            quot_in  = '0;
            step_in  = '0;
            state_in = B_DIV;
         end
         B_DIV: begin
            // quotient never exceeds the strength magnitude, so QUOT_W steps suffice
            if (rem_ff >= dsr_ff) begin
               rem_in  = rem_ff - dsr_ff;
               quot_in = {quot_ff[rbhs_pkg::QUOT_W-2:0], 1'b1};
            end else begin
               quot_in = {quot_ff[rbhs_pkg::QUOT_W-2:0], 1'b0};
            end
            dsr_in  = dsr_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == rbhs_pkg::STEP_W'(rbhs_pkg::QUOT_W - 1)) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (!out_valid_in) begin
               out_valid_in  = 1'b1;
               out_height_in = active_ff ? clamped : old_ff;
               out_we_in     = changed;
               out_status_in = status_ff;
               out_count_in  = count_next;
               out_done_in   = last_ff;
               counter_in    = last_ff ? '0 : count_next;
               state_in      = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         counter_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         out_valid_ff <= out_valid_in;
      end
      old_ff        <= old_in;
      last_ff       <= last_in;
      status_ff     <= status_in;
      active_ff     <= active_in;
      rad_ff        <= rad_in;
      root_ff       <= root_in;
      bit_ff        <= bit_in;
      step_ff       <= step_in;
      edge_ff       <= edge_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      dsr_ff        <= dsr_in;
      quot_ff       <= quot_in;
      out_height_ff <= out_height_in;
      out_we_ff     <= out_we_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
      out_done_ff   <= out_done_in;
   end

endmodule

// ----- sv/radial_brush_height_stamp_top.sv -----
// path from request to response: the front end (idle, square, push states), a queue pop, then
// for an active cell inside the brush 16 square root steps, numerator, multiply, 18 divide steps, then output
// inside the brush the request rate is set by the bit-serial square root and divider in the back
// end; outside it by the front end, which takes a new request once the last is pushed to the queue
// reset: synchronous, clears the queue, the change counter, the response valid flag and
// all brush registers to zero
`include "assert_macros.svh"

module radial_brush_height_stamp_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [rbhs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rbhs_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rbhs_pkg::CELL_W-1:0]        req_cell_x,
   input  logic [rbhs_pkg::CELL_W-1:0]        req_cell_y,
   input  logic [rbhs_pkg::HEIGHT_W-1:0]      req_old_height,
   input  logic                               req_final_cell,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [rbhs_pkg::HEIGHT_W-1:0]      rsp_new_height,
   output logic                               rsp_write_enable,
   output logic [rbhs_pkg::STATUS_W-1:0]      rsp_pass_status,
   output logic [rbhs_pkg::COUNT_W-1:0]       rsp_cells_changed,
   output logic                               rsp_pass_done
);

   rbhs_pkg::cfg_type         cfg_ff, cfg_in;
   rbhs_pkg::fifo_status_type fifo_stat;
   rbhs_pkg::entry_type       push_data, pop_data;
   logic                      fifo_push, fifo_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            rbhs_pkg::CSR_CENTER_X: cfg_in.center_x = csr_wdata[rbhs_pkg::POS_W-1:0];
            rbhs_pkg::CSR_CENTER_Y: cfg_in.center_y = csr_wdata[rbhs_pkg::POS_W-1:0];
            rbhs_pkg::CSR_RADIUS:   cfg_in.radius   = csr_wdata[rbhs_pkg::RAD_W-1:0];
            rbhs_pkg::CSR_STRENGTH: cfg_in.strength = csr_wdata[rbhs_pkg::STR_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rbhs_front u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cell_x     (req_cell_x),
      .req_cell_y     (req_cell_y),
      .req_old_height (req_old_height),
      .req_final_cell (req_final_cell),
      .fifo_stat      (fifo_stat),
      .fifo_push      (fifo_push),
      .fifo_data      (push_data)
   );

   rbhs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (push_data),
      .pop       (fifo_pop),
      .pop_data  (pop_data),
      .stat      (fifo_stat)
   );

   rbhs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .fifo_stat         (fifo_stat),
      .fifo_data         (pop_data),
      .fifo_pop          (fifo_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_new_height    (rsp_new_height),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_pass_status   (rsp_pass_status),
      .rsp_cells_changed (rsp_cells_changed),
      .rsp_pass_done     (rsp_pass_done)
   );

   `RBHS_ASSERT_NOW(a_no_push_when_full, fifo_push, !fifo_stat.full)
   `RBHS_ASSERT_NOW(a_no_pop_when_empty, fifo_pop, !fifo_stat.empty)
   `RBHS_ASSERT_NEXT(a_push_fills, fifo_push && !fifo_pop, !fifo_stat.empty)
   `RBHS_ASSERT_NOW(a_write_only_applied, rsp_valid && rsp_write_enable,
      rsp_pass_status == rbhs_pkg::STATUS_APPLIED && rsp_cells_changed != '0)

endmodule

// ----- tb/radial_brush_height_stamp_top_test.sv -----
// self-checking testbench for the radial brush height stamp: directed table, then random passes
module radial_brush_height_stamp_top_test;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 400;
   localparam int PHASES      = 8;
   localparam int PHASE_CELLS = 115;
   localparam int SETTLE      = 60;

   typedef struct packed {
      logic [rbhs_pkg::HEIGHT_W-1:0] height;
      logic                          we;
      logic [rbhs_pkg::STATUS_W-1:0] status;
      logic [rbhs_pkg::COUNT_W-1:0]  count;
      logic                          done;
   } stamp_result_type;

   typedef enum logic [1:0] {ROW_BRUSH, ROW_CELL, ROW_KNOWN} row_kind_type;

   typedef struct {
      row_kind_type                  kind;
      int                            cx;
      int                            cy;
      int                            rad;
      int                            str;
      logic [rbhs_pkg::CELL_W-1:0]   x;
      logic [rbhs_pkg::CELL_W-1:0]   y;
      logic [rbhs_pkg::HEIGHT_W-1:0] h;
      logic                          last;
      stamp_result_type              want;
   } stimulus_row_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_write_enable;
   logic [rbhs_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [rbhs_pkg::CSR_DATA_W-1:0] csr_wdata;
   logic                            req_valid;
   logic                            req_stall;
   logic [rbhs_pkg::CELL_W-1:0]     req_cell_x;
   logic [rbhs_pkg::CELL_W-1:0]     req_cell_y;
   logic [rbhs_pkg::HEIGHT_W-1:0]   req_old_height;
   logic                            req_final_cell;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [rbhs_pkg::HEIGHT_W-1:0]   rsp_new_height;
   logic                            rsp_write_enable;
   logic [rbhs_pkg::STATUS_W-1:0]   rsp_pass_status;
   logic [rbhs_pkg::COUNT_W-1:0]    rsp_cells_changed;
   logic                            rsp_pass_done;

   // shadow copy of the brush registers and the change counter
   logic [rbhs_pkg::POS_W-1:0]        brush_cx;
   logic [rbhs_pkg::POS_W-1:0]        brush_cy;
   logic signed [rbhs_pkg::RAD_W-1:0] brush_rad;
   logic signed [rbhs_pkg::STR_W-1:0] brush_str;
   logic [rbhs_pkg::COUNT_W-1:0]      changed_total;

   stamp_result_type pending_stamps[$];
   stimulus_row_type brush_rows[$];

   bit quiet = 1'b0;
   bit hold_request = 1'b0;
   int mismatches = 0;
   int cycle_count = 0;

   radial_brush_height_stamp_top DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cell_x        (req_cell_x),
      .req_cell_y        (req_cell_y),
      .req_old_height    (req_old_height),
      .req_final_cell    (req_final_cell),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_new_height    (rsp_new_height),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_pass_status   (rsp_pass_status),
      .rsp_cells_changed (rsp_cells_changed),
      .rsp_pass_done     (rsp_pass_done)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic longint floor_sqrt(longint v);
      longint root;
      longint cand;
      root = 0;
      for (int b = 17; b >= 0; b--) begin
         cand = root | (longint'(1) << b);
         if (cand * cand <= v) root = cand;
      end
      return root;
   endfunction

   // expected response for one cell; advances the change counter
   function automatic stamp_result_type stamp_cell(logic [rbhs_pkg::CELL_W-1:0] x,
                                                   logic [rbhs_pkg::CELL_W-1:0] y,
                                                   logic [rbhs_pkg::HEIGHT_W-1:0] h,
                                                   logic last);
      stamp_result_type res;
      longint dx, dy, d2, r, s, mag, root_dist, span, delta, nh;
      res.height = h;
      res.we     = 1'b0;
      res.status = rbhs_pkg::STATUS_APPLIED;
      res.done   = last;
      if (brush_rad < 0) begin
         res.status = rbhs_pkg::STATUS_REJECT;
      end else if (brush_str == 0) begin
         res.status = rbhs_pkg::STATUS_NOOP;
      end else if (int'(x) < rbhs_pkg::MAX_WIDTH && int'(y) < rbhs_pkg::MAX_HEIGHT) begin
         dx = (longint'(x) << rbhs_pkg::FRAC_BITS) - longint'(brush_cx);
         dy = (longint'(y) << rbhs_pkg::FRAC_BITS) - longint'(brush_cy);
         d2 = dx * dx + dy * dy;
         r  = longint'(brush_rad);
         if (d2 <= r * r) begin
            s         = longint'(brush_str);
            mag       = (s < 0) ? -s : s;
            root_dist = floor_sqrt(d2);
            span      = 2 * r + (longint'(1) << rbhs_pkg::FRAC_BITS);
            delta     = (mag * (span - 2 * root_dist)) / span;
            if (s < 0) delta = -delta;
            nh = longint'(h) + delta;
            if (nh < 0) nh = 0;
            if (nh > longint'(rbhs_pkg::HEIGHT_ONE)) nh = longint'(rbhs_pkg::HEIGHT_ONE);
            res.height = rbhs_pkg::HEIGHT_W'(nh);
            if (nh != longint'(h)) begin
               res.we = 1'b1;
               if (changed_total != rbhs_pkg::COUNT_MAX) changed_total = changed_total + 1'b1;
            end
         end
      end
      res.count = changed_total;
      if (last) changed_total = '0;
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [rbhs_pkg::CELL_W-1:0] clamp_cell(int v);
      if (v < 0) return '0;
      if (v > 1023) return '1;
      return rbhs_pkg::CELL_W'(v);
   endfunction

   function automatic void add_brush(int cx, int cy, int rad, int str);
      stimulus_row_type row;
      row.kind = ROW_BRUSH;
      row.cx   = cx;
      row.cy   = cy;
      row.rad  = rad;
      row.str  = str;
      brush_rows.push_back(row);
   endfunction

   function automatic void add_cell(int x, int y, int h, logic last);
      stimulus_row_type row;
      row.kind = ROW_CELL;
      row.x    = rbhs_pkg::CELL_W'(x);
      row.y    = rbhs_pkg::CELL_W'(y);
      row.h    = rbhs_pkg::HEIGHT_W'(h);
      row.last = last;
      row.want = '0;
      brush_rows.push_back(row);
   endfunction

   function automatic void add_known(int x, int y, int h, logic last, int eh, logic ewe,
                                     logic [rbhs_pkg::STATUS_W-1:0] est, int ecnt);
      stimulus_row_type row;
      row.kind = ROW_KNOWN;
      row.x    = rbhs_pkg::CELL_W'(x);
      row.y    = rbhs_pkg::CELL_W'(y);
      row.h    = rbhs_pkg::HEIGHT_W'(h);
      row.last = last;
      row.want = '{height: rbhs_pkg::HEIGHT_W'(eh), we: ewe, status: est,
                   count: rbhs_pkg::COUNT_W'(ecnt), done: last};
      brush_rows.push_back(row);
   endfunction

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         if (mismatches < 40)
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   task automatic write_reg(logic [rbhs_pkg::CSR_IDX_W-1:0] idx,
                            logic [rbhs_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_wdata        = data;
      case (idx)
         rbhs_pkg::CSR_CENTER_X: brush_cx  = data[rbhs_pkg::POS_W-1:0];
         rbhs_pkg::CSR_CENTER_Y: brush_cy  = data[rbhs_pkg::POS_W-1:0];
         rbhs_pkg::CSR_RADIUS:   brush_rad = data[rbhs_pkg::RAD_W-1:0];
         rbhs_pkg::CSR_STRENGTH: brush_str = data[rbhs_pkg::STR_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic load_brush(int cx, int cy, int rad, int str);
      write_reg(rbhs_pkg::CSR_CENTER_X, rbhs_pkg::CSR_DATA_W'(cx));
      write_reg(rbhs_pkg::CSR_CENTER_Y, rbhs_pkg::CSR_DATA_W'(cy));
      write_reg(rbhs_pkg::CSR_RADIUS, rbhs_pkg::CSR_DATA_W'(rad));
      write_reg(rbhs_pkg::CSR_STRENGTH, rbhs_pkg::CSR_DATA_W'(str));
   endtask

   // offer one cell, hold it until taken, then queue what it should produce
   task automatic send_cell(logic [rbhs_pkg::CELL_W-1:0] x, logic [rbhs_pkg::CELL_W-1:0] y,
                            logic [rbhs_pkg::HEIGHT_W-1:0] h, logic last, bit known,
                            stamp_result_type typed);
      stamp_result_type predicted;
      req_cell_x     = x;
      req_cell_y     = y;
      req_old_height = h;
      req_final_cell = last;
      req_valid      = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      predicted = stamp_cell(x, y, h, last);
      pending_stamps.push_back(known ? typed : predicted);
   endtask

   task automatic idle_gap();
      int n;
      n = (quiet || hold_request) ? 0 : pick_gap();
      if (n != 0) begin
         req_valid = 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic drain_block();
      req_valid = 1'b0;
      while (pending_stamps.size() != 0) @(negedge clock);
   endtask

   // receiver: random stalls plus one long hold to back the block up
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            rsp_stall = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            n = pick_gap();
            if (n != 0) begin
               rsp_stall = 1'b1;
               repeat (n) @(negedge clock);
               rsp_stall = 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      stamp_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_stamps.size() == 0) begin
            if (mismatches < 40)
               $display("%0t: unexpected response, new_height expected none, actual %0d",
                        $time, rsp_new_height);
            mismatches++;
         end else begin
            want = pending_stamps.pop_front();
            check_field("new_height", want.height, rsp_new_height);
            check_field("write_enable", want.we, rsp_write_enable);
            check_field("pass_status", want.status, rsp_pass_status);
            check_field("cells_changed", want.count, rsp_cells_changed);
            check_field("pass_done", want.done, rsp_pass_done);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      stimulus_row_type row;
      int r, rad, str, spread, sgn;
      logic [rbhs_pkg::CELL_W-1:0] x, y;
      logic [rbhs_pkg::HEIGHT_W-1:0] h;
      logic last;

      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_valid        = 1'b0;
      req_cell_x       = '0;
      req_cell_y       = '0;
      req_old_height   = '0;
      req_final_cell   = 1'b0;
      brush_cx         = '0;
      brush_cy         = '0;
      brush_rad        = '0;
      brush_str        = '0;
      changed_total    = '0;

      // reset registers: zero strength means nothing is applied
      add_known(0, 0, 1234, 1'b0, 1234, 1'b0, rbhs_pkg::STATUS_NOOP, 0);
      add_brush(0, 0, -1, 65536);
      add_known(5, 5, 70000, 1'b0, 70000, 1'b0, rbhs_pkg::STATUS_REJECT, 0);
      // negative radius wins over zero strength
      add_brush(0, 0, -65536, 0);
      add_known(1023, 1023, 0, 1'b1, 0, 1'b0, rbhs_pkg::STATUS_REJECT, 0);
      // zero radius: only the center cell is inside, full strength there
      add_brush(640, 640, 0, 65536);
      add_known(10, 10, 0, 1'b0, 65536, 1'b1, rbhs_pkg::STATUS_APPLIED, 1);
      add_known(11, 10, 500, 1'b0, 500, 1'b0, rbhs_pkg::STATUS_APPLIED, 1);
      add_known(10, 10, 65536, 1'b0, 65536, 1'b0, rbhs_pkg::STATUS_APPLIED, 1);
      add_known(10, 10, 131071, 1'b1, 65536, 1'b1, rbhs_pkg::STATUS_APPLIED, 2);
      add_known(10, 10, 7, 1'b0, 65536, 1'b1, rbhs_pkg::STATUS_APPLIED, 1);
      add_brush(32768, 32768, 65535, -65536);
      add_known(512, 512, 65536, 1'b0, 0, 1'b1, rbhs_pkg::STATUS_APPLIED, 2);
      add_known(512, 512, 0, 1'b0, 0, 1'b0, rbhs_pkg::STATUS_APPLIED, 2);
      add_cell(0, 0, 65536, 1'b0);
      add_cell(1023, 1023, 40000, 1'b0);
      add_cell(1023, 0, 1, 1'b1);
      // far corner: squared distance no longer fits 32 bits
      add_brush(65535, 65535, 65535, 1);
      add_cell(0, 0, 100, 1'b0);
      add_cell(1023, 1023, 65535, 1'b0);
      add_cell(1023, 1022, 131071, 1'b0);
      add_brush(100, 200, 300, 40000);
      add_cell(1, 3, 30000, 1'b0);
      add_cell(2, 3, 65000, 1'b0);
      add_cell(6, 3, 20000, 1'b1);
      add_cell(0, 0, 0, 1'b0);
      add_cell(1023, 0, 12345, 1'b1);

      repeat (12) @(negedge clock);
      reset = 1'b0;

      foreach (brush_rows[i]) begin
         row = brush_rows[i];
         if (row.kind == ROW_BRUSH) begin
            drain_block();
            load_brush(row.cx, row.cy, row.rad, row.str);
         end else begin
            send_cell(row.x, row.y, row.h, row.last, row.kind == ROW_KNOWN, row.want);
            idle_gap();
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         drain_block();
         r = $urandom_range(0, 9);
         if (p == 0) rad = -int'($urandom_range(1, 65536));
         else if (p == 2) rad = 65535;
         else if (r < 5) rad = $urandom_range(0, 600);
         else if (r < 8) rad = $urandom_range(600, 8000);
         else rad = $urandom_range(0, 65535);
         r = $urandom_range(0, 9);
         sgn = ($urandom_range(0, 1) != 0) ? 1 : -1;
         if (p == 1) str = 0;
         else if (r == 0) str = 65536;
         else if (r == 1) str = -65536;
         else if (r == 2) str = int'($urandom_range(1, 64)) * sgn;
         else str = int'($urandom_range(0, 131072)) - 65536;
         load_brush($urandom_range(0, 65535), $urandom_range(0, 65535), rad, str);
         quiet = (p == 3);
         if (p == 4) hold_request = 1'b1;

         for (int k = 0; k < PHASE_CELLS; k++) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
               spread = (brush_rad < 0) ? 8 : (int'(brush_rad) >>> rbhs_pkg::FRAC_BITS) + 2;
               x = clamp_cell(int'(brush_cx >> rbhs_pkg::FRAC_BITS)
                              + int'($urandom_range(0, 2 * spread)) - spread);
               y = clamp_cell(int'(brush_cy >> rbhs_pkg::FRAC_BITS)
                              + int'($urandom_range(0, 2 * spread)) - spread);
            end else begin
               x = rbhs_pkg::CELL_W'($urandom);
               y = rbhs_pkg::CELL_W'($urandom);
            end
            r = $urandom_range(0, 9);
            if (r < 6) h = rbhs_pkg::HEIGHT_W'($urandom_range(0, 65536));
            else if (r == 6) h = '0;
            else if (r == 7) h = rbhs_pkg::HEIGHT_ONE;
            else if (r == 8) h = rbhs_pkg::HEIGHT_W'($urandom_range(65537, 131071));
            else h = rbhs_pkg::HEIGHT_W'($urandom);
            last = ($urandom_range(0, 39) == 0) || (k == PHASE_CELLS - 1);
            send_cell(x, y, h, last, 1'b0, '0);
            idle_gap();
         end
      end

      drain_block();
      quiet = 1'b0;
      repeat (SETTLE) @(negedge clock);
      if (mismatches == 0 && pending_stamps.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
